[hw/rtl/gedr_pkg.sv]
// gedr_pkg: shared types and constants of the gpio edge debounce reporter
// holds status codes, register indexes and the configuration struct
// no dependencies
`timescale 1ns / 1ps

package gedr_pkg;

   localparam int unsigned PIN_LIMIT   = 16;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned TICK_W      = 32;
   localparam int unsigned THRESH_W    = 16;
   localparam int unsigned STATUS_W    = 3;

   localparam logic [STATUS_W-1:0] ST_INACTIVE = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BOUNCE   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RISING   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FALLING  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] REG_ACTIVE_MASK  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RISING_MASK  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FALLING_MASK = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE_0   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE_1   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE_2   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE_3   = 3'd6;

   typedef struct packed {
      logic [PIN_LIMIT-1:0]              active_mask;
      logic [PIN_LIMIT-1:0]              rising_mask;
      logic [PIN_LIMIT-1:0]              falling_mask;
      logic [PIN_LIMIT-1:0][THRESH_W-1:0] threshold;
   } cfg_type;

endpackage

[hw/rtl/gedr_csr.sv]
// gedr_csr: configuration registers of the debounce reporter
// depends on gedr_pkg for register indexes and cfg_type
`timescale 1ns / 1ps

module gedr_csr
   import gedr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_ACTIVE_MASK:  cfg_in.active_mask  = csr_write_data[PIN_LIMIT-1:0];
            REG_RISING_MASK:  cfg_in.rising_mask  = csr_write_data[PIN_LIMIT-1:0];
            REG_FALLING_MASK: cfg_in.falling_mask = csr_write_data[PIN_LIMIT-1:0];
            REG_DEBOUNCE_0:   cfg_in.threshold[3:0]   = csr_write_data;
            REG_DEBOUNCE_1:   cfg_in.threshold[7:4]   = csr_write_data;
            REG_DEBOUNCE_2:   cfg_in.threshold[11:8]  = csr_write_data;
            REG_DEBOUNCE_3:   cfg_in.threshold[15:12] = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hw/rtl/gedr_tick_mem.sv]
// gedr_tick_mem: last accepted tick per pin, one read and one write port
// registered read with write forwarding; unwritten entries read as the empty tick
// depends on gedr_pkg for the tick width
`timescale 1ns / 1ps

module gedr_tick_mem
   import gedr_pkg::*;
#(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned ADDR_W     = 4,
   parameter logic [TICK_W-1:0] EMPTY_TICK = 32'd0
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [TICK_W-1:0] wr_data,
   output logic [TICK_W-1:0] rd_data
);

   logic [TICK_W-1:0] tick_mem_ff [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [TICK_W-1:0] rdata_ff;
   logic              rvalid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tick_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rdata_ff <= wr_data;
         end else begin
            rdata_ff <= tick_mem_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rvalid_ff <= (wr_en && (wr_addr == rd_addr)) || valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : EMPTY_TICK;

endmodule

[hw/rtl/gpio_edge_debounce_reporter_top.sv]
// gpio_edge_debounce_reporter_top: per-pin debounce of pin interrupts with edge reports
// depends on gedr_pkg, gedr_csr and gedr_tick_mem
//
// usage:
//   req_ channel carries one pin interrupt (pin, tick, level, sink full flag)
//   rsp_ channel returns exactly one result per request: status, report fields
//   and the running dropped-report count
//   csr_ port writes the masks and debounce words; the user writes only while the block is idle, unenforced
// an accepted request is registered into stage two, whose result loads the output register
// throughput: one request per cycle when not stalled; stage one reads the per-pin tick
//   memory, stage two compares, writes the memory back and loads the output register
// a same-pin request right behind another picks up the new tick by forwarding
// at reset all pins read as having no accepted interrupt, the dropped count
//   and all csr registers clear, and no request or result is held
// when rsp_ready is low the output register holds its result, the second
//   stage holds one more request, and req_ready drops only when both are full
`timescale 1ns / 1ps

module gpio_edge_debounce_reporter_top
   import gedr_pkg::*;
#(
   parameter int unsigned PIN_COUNT  = 16,
   parameter logic [31:0] EMPTY_TICK = 32'd0
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_pin_number,
   input  logic [TICK_W-1:0]      req_tick_now,
   input  logic                   req_pin_level,
   input  logic                   req_sink_full,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status_code,
   output logic                   rsp_report_valid,
   output logic [3:0]             rsp_report_pin,
   output logic                   rsp_report_level,
   output logic [TICK_W-1:0]      rsp_overflow_count,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int unsigned ADDR_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

   cfg_type cfg;

   logic              s1_valid_ff;
   logic [7:0]        s1_pin_ff;
   logic [TICK_W-1:0] s1_tick_ff;
   logic              s1_level_ff;
   logic              s1_full_ff;

   logic [TICK_W-1:0] dropped_ff;
   logic [TICK_W-1:0] dropped_in;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic                report_valid_ff;
   logic [3:0]          report_pin_ff;
   logic                report_level_ff;
   logic [TICK_W-1:0]   overflow_ff;

   logic                req_fire;
   logic                req_in_range;
   logic                out_load;
   logic                commit;
   logic [TICK_W-1:0]   last_tick;
   logic                s1_in_range;
   logic                s1_active;
   logic [TICK_W-1:0]   elapsed;
   logic [THRESH_W-1:0] threshold;
   logic                bounce;
   logic                accept;
   logic [TICK_W-1:0]   stored_tick;
   logic                rise_rep;
   logic                fall_rep;
   logic [STATUS_W-1:0] status_in;
   logic                report_in;

   gedr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_load;
   assign req_fire  = req_valid && req_ready;
   assign commit    = s1_valid_ff && out_load;

   assign req_in_range = (req_pin_number[7:4] == 4'd0) && (req_pin_number < 8'(PIN_COUNT));

   gedr_tick_mem #(
      .DEPTH      (PIN_COUNT),
      .ADDR_W     (ADDR_W),
      .EMPTY_TICK (EMPTY_TICK)
   ) u_tick_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire && req_in_range),
      .rd_addr (req_pin_number[ADDR_W-1:0]),
      .wr_en   (commit && accept),
      .wr_addr (s1_pin_ff[ADDR_W-1:0]),
      .wr_data (stored_tick),
      .rd_data (last_tick)
   );

   always_comb begin
      s1_in_range = (s1_pin_ff[7:4] == 4'd0) && (s1_pin_ff < 8'(PIN_COUNT));
      s1_active   = s1_in_range && cfg.active_mask[s1_pin_ff[3:0]];
      threshold   = cfg.threshold[s1_pin_ff[3:0]];
      elapsed     = s1_tick_ff - last_tick;
      bounce      = (last_tick != EMPTY_TICK) && (elapsed <= {16'd0, threshold});
      accept      = s1_active && !bounce;
      stored_tick = (s1_tick_ff == EMPTY_TICK) ? (EMPTY_TICK + 32'd1) : s1_tick_ff;
      rise_rep    = s1_level_ff && cfg.rising_mask[s1_pin_ff[3:0]];
      fall_rep    = !s1_level_ff && cfg.falling_mask[s1_pin_ff[3:0]];
      report_in   = accept && (rise_rep || fall_rep);
      if (!s1_active) begin
         status_in = ST_INACTIVE;
      end else if (bounce) begin
         status_in = ST_BOUNCE;
      end else if (rise_rep) begin
         status_in = ST_RISING;
      end else if (fall_rep) begin
         status_in = ST_FALLING;
      end else begin
         status_in = ST_ACCEPTED;
      end
      dropped_in = (report_in && s1_full_ff) ? (dropped_ff + 32'd1) : dropped_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dropped_ff   <= '0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (out_load) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (commit) begin
            dropped_ff <= dropped_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pin_ff   <= req_pin_number;
         s1_tick_ff  <= req_tick_now;
         s1_level_ff <= req_pin_level;
         s1_full_ff  <= req_sink_full;
      end
      if (commit) begin
         status_ff       <= status_in;
         report_valid_ff <= report_in;
         report_pin_ff   <= report_in ? s1_pin_ff[3:0] : 4'd0;
         report_level_ff <= report_in ? s1_level_ff : 1'b0;
         overflow_ff     <= dropped_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status_code    = status_ff;
   assign rsp_report_valid   = report_valid_ff;
   assign rsp_report_pin     = report_pin_ff;
   assign rsp_report_level   = report_level_ff;
   assign rsp_overflow_count = overflow_ff;

endmodule

[bench/gedr_checker.sv]
// gedr_checker: watches the request, result and csr ports of the debounce reporter
// predicts each result from its own copy of masks, thresholds and per-pin ticks
// depends on gedr_pkg only
`timescale 1ns / 1ps

module gedr_checker
   import gedr_pkg::*;
#(
   parameter int unsigned PIN_COUNT  = 16,
   parameter logic [31:0] EMPTY_TICK = 32'd0
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [7:0]             req_pin_number,
   input  logic [TICK_W-1:0]      req_tick_now,
   input  logic                   req_pin_level,
   input  logic                   req_sink_full,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [STATUS_W-1:0]    rsp_status_code,
   input  logic                   rsp_report_valid,
   input  logic [3:0]             rsp_report_pin,
   input  logic                   rsp_report_level,
   input  logic [TICK_W-1:0]      rsp_overflow_count,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic                   drain_done,
   output int unsigned            fail_count,
   output int unsigned            pending,
   output int unsigned            checked_count,
   output int unsigned            bounce_count,
   output int unsigned            report_count
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                rep_valid;
      logic [3:0]          rep_pin;
      logic                rep_level;
      logic [TICK_W-1:0]   overflow;
   } irq_outcome_type;

   irq_outcome_type   outcome_q[$];
   logic [15:0]       active_m;
   logic [15:0]       rising_m;
   logic [15:0]       falling_m;
   logic [63:0]       debounce_w [4];
   logic [TICK_W-1:0] last_tick [PIN_LIMIT];
   logic [TICK_W-1:0] dropped;
   bit                leftover_checked;

   initial begin
      fail_count       = 0;
      pending          = 0;
      checked_count    = 0;
      bounce_count     = 0;
      report_count     = 0;
      leftover_checked = 1'b0;
   end

   task automatic report_error(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // debounce decision for one interrupt; updates the pin tick table and drop count
   function automatic irq_outcome_type judge_interrupt(input logic [7:0] pin,
                                                       input logic [TICK_W-1:0] now,
                                                       input logic level,
                                                       input logic full);
      irq_outcome_type   o;
      logic [3:0]        p;
      logic [15:0]       limit;
      logic [TICK_W-1:0] elapsed;
      o        = '0;
      o.status = ST_ACCEPTED;
      p        = pin[3:0];
      if (pin >= 8'd16 || pin >= PIN_COUNT || !active_m[p]) begin
         o.status = ST_INACTIVE;
      end else begin
         limit   = debounce_w[p[3:2]][{p[1:0], 4'b0000} +: 16];
         elapsed = now - last_tick[p];
         if (last_tick[p] != EMPTY_TICK && elapsed <= {16'd0, limit}) begin
            o.status = ST_BOUNCE;
         end else begin
            last_tick[p] = (now == EMPTY_TICK) ? EMPTY_TICK + 32'd1 : now;
            if (level && rising_m[p]) begin
               o.status = ST_RISING;
            end else if (!level && falling_m[p]) begin
               o.status = ST_FALLING;
            end
            if (o.status == ST_RISING || o.status == ST_FALLING) begin
               o.rep_valid = 1'b1;
               o.rep_pin   = p;
               o.rep_level = level;
               if (full) begin
                  dropped = dropped + 32'd1;
               end
            end
         end
      end
      o.overflow = dropped;
      return o;
   endfunction

   always @(posedge clock) begin
      irq_outcome_type want;
      irq_outcome_type got;
      if (reset) begin
         active_m  = '0;
         rising_m  = '0;
         falling_m = '0;
         dropped   = '0;
         for (int i = 0; i < 4; i++) debounce_w[i] = '0;
         for (int i = 0; i < PIN_LIMIT; i++) last_tick[i] = EMPTY_TICK;
         outcome_q.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_ACTIVE_MASK:  active_m      = csr_write_data[15:0];
               REG_RISING_MASK:  rising_m      = csr_write_data[15:0];
               REG_FALLING_MASK: falling_m     = csr_write_data[15:0];
               REG_DEBOUNCE_0:   debounce_w[0] = csr_write_data;
               REG_DEBOUNCE_1:   debounce_w[1] = csr_write_data;
               REG_DEBOUNCE_2:   debounce_w[2] = csr_write_data;
               REG_DEBOUNCE_3:   debounce_w[3] = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            outcome_q.push_back(judge_interrupt(req_pin_number, req_tick_now,
                                                req_pin_level, req_sink_full));
         end
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               report_error("result with no request outstanding");
            end else begin
               want = outcome_q.pop_front();
               got  = {rsp_status_code, rsp_report_valid, rsp_report_pin,
                       rsp_report_level, rsp_overflow_count};
               if (got !== want) begin
                  report_error($sformatf(
                     "result %0d: got %0d %0b %0d %0b %0d, want %0d %0b %0d %0b %0d",
                     checked_count, got.status, got.rep_valid, got.rep_pin, got.rep_level,
                     got.overflow, want.status, want.rep_valid, want.rep_pin,
                     want.rep_level, want.overflow));
               end
               checked_count++;
               if (want.status == ST_BOUNCE) bounce_count++;
               if (want.rep_valid) report_count++;
            end
         end
         if (drain_done && !leftover_checked) begin
            leftover_checked = 1'b1;
            if (outcome_q.size() != 0) begin
               report_error($sformatf("%0d results never arrived", outcome_q.size()));
            end
         end
      end
      pending = outcome_q.size();
   end

endmodule

[bench/tb_gpio_edge_debounce_reporter_top.sv]
// tb_gpio_edge_debounce_reporter_top: stimulus and verdict for the debounce reporter
// drives directed and random pin interrupts over several csr settings with random stalls
// depends on gedr_pkg, gpio_edge_debounce_reporter_top and gedr_checker
`timescale 1ns / 1ps

module tb_gpio_edge_debounce_reporter_top;
   import gedr_pkg::*;

   localparam int unsigned PINS        = 16;
   localparam logic [31:0] EMPTY_VALUE = 32'd0;
   localparam int          DRAIN_WAIT  = 6;
   localparam int          LONG_HOLD   = 64;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_pin_number = '0;
   logic [TICK_W-1:0]      req_tick_now = '0;
   logic                   req_pin_level = 1'b0;
   logic                   req_sink_full = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [STATUS_W-1:0]    rsp_status_code;
   logic                   rsp_report_valid;
   logic [3:0]             rsp_report_pin;
   logic                   rsp_report_level;
   logic [TICK_W-1:0]      rsp_overflow_count;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;
   logic                   drain_done = 1'b0;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned checked_count;
   int unsigned bounce_count;
   int unsigned report_count;

   bit          send_idle = 1'b1;
   bit          recv_idle = 1'b1;
   int unsigned hold_asked = 0;
   int unsigned hold_served = 0;
   int unsigned sent_count = 0;
   int unsigned settings_count = 0;

   always #5 clock = ~clock;

   gpio_edge_debounce_reporter_top #(
      .PIN_COUNT  (PINS),
      .EMPTY_TICK (EMPTY_VALUE)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pin_number     (req_pin_number),
      .req_tick_now       (req_tick_now),
      .req_pin_level      (req_pin_level),
      .req_sink_full      (req_sink_full),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status_code    (rsp_status_code),
      .rsp_report_valid   (rsp_report_valid),
      .rsp_report_pin     (rsp_report_pin),
      .rsp_report_level   (rsp_report_level),
      .rsp_overflow_count (rsp_overflow_count),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   gedr_checker #(
      .PIN_COUNT  (PINS),
      .EMPTY_TICK (EMPTY_VALUE)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pin_number     (req_pin_number),
      .req_tick_now       (req_tick_now),
      .req_pin_level      (req_pin_level),
      .req_sink_full      (req_sink_full),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status_code    (rsp_status_code),
      .rsp_report_valid   (rsp_report_valid),
      .rsp_report_pin     (rsp_report_pin),
      .rsp_report_level   (rsp_report_level),
      .rsp_overflow_count (rsp_overflow_count),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .drain_done         (drain_done),
      .fail_count         (fail_count),
      .pending            (pending),
      .checked_count      (checked_count),
      .bounce_count       (bounce_count),
      .report_count       (report_count)
   );

   // result side: random stall bursts, plus a long hold when one is asked for
   initial begin
      forever begin
         @(negedge clock);
         if (hold_asked != hold_served) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            hold_served++;
         end else if (recv_idle && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #5ms;
      $display("timeout with %0d results outstanding", pending);
      $display("Simulation FAILED");
      $finish;
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_config(input logic [15:0] active, input logic [15:0] rising,
                             input logic [15:0] falling, input logic [63:0] d0,
                             input logic [63:0] d1, input logic [63:0] d2,
                             input logic [63:0] d3);
      write_reg(REG_ACTIVE_MASK, {48'd0, active});
      write_reg(REG_RISING_MASK, {48'd0, rising});
      write_reg(REG_FALLING_MASK, {48'd0, falling});
      write_reg(REG_DEBOUNCE_0, d0);
      write_reg(REG_DEBOUNCE_1, d1);
      write_reg(REG_DEBOUNCE_2, d2);
      write_reg(REG_DEBOUNCE_3, d3);
      settings_count++;
   endtask

   function automatic logic [63:0] rand_debounce_word(input int unsigned thr_max);
      logic [63:0] w;
      w = '0;
      for (int i = 0; i < 4; i++) w[i*16 +: 16] = 16'($urandom_range(0, thr_max));
      return w;
   endfunction

   // wait until every request has its result, then let the pipeline settle
   task automatic wait_drained;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic push_request(input logic [7:0] pin, input logic [31:0] tick,
                               input logic level, input logic full);
      int gap;
      gap = (send_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_pin_number <= pin;
      req_tick_now   <= tick;
      req_pin_level  <= level;
      req_sink_full  <= full;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   task automatic end_requests;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // mostly in-range pins on a slowly advancing tick, some noise pins and random ticks
   task automatic run_random(input int count, input logic [31:0] start_tick,
                             input int unsigned step_max);
      logic [31:0] tick_base;
      logic [7:0]  pin;
      logic [31:0] tick;
      int          r;
      tick_base = start_tick;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            pin  = 8'($urandom_range(16, 255));
            tick = $urandom;
         end else if (r < 12) begin
            pin  = 8'($urandom_range(0, 15));
            tick = $urandom;
         end else begin
            pin       = 8'($urandom_range(0, 15));
            tick_base = tick_base + $urandom_range(0, step_max);
            tick      = tick_base;
         end
         push_request(pin, tick, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: bounce edges, wrap, empty entry, zero tick, out of range pins
      write_reg(REG_UNUSED, '1);
      set_config(16'h7FFF, 16'h00FF, 16'h0F0F, 64'h0100_0000_FFFF_0010,
                 64'h0040_0030_0020_0010, 64'h0040_0030_0020_0010,
                 64'h0040_0030_0020_0010);
      push_request(8'd0, 32'd100, 1'b1, 1'b0);
      push_request(8'd0, 32'd110, 1'b1, 1'b0);
      push_request(8'd0, 32'd116, 1'b0, 1'b0);
      push_request(8'd0, 32'd117, 1'b0, 1'b0);
      push_request(8'd15, 32'd120, 1'b1, 1'b1);
      push_request(8'd16, 32'd121, 1'b1, 1'b1);
      push_request(8'd255, 32'hFFFF_FFFF, 1'b1, 1'b1);
      push_request(8'hF0, 32'd122, 1'b0, 1'b0);
      push_request(8'd1, 32'hFFFF_FFF0, 1'b1, 1'b1);
      push_request(8'd1, 32'd5, 1'b1, 1'b1);
      push_request(8'd2, 32'd0, 1'b0, 1'b1);
      push_request(8'd2, 32'd1, 1'b0, 1'b1);
      push_request(8'd2, 32'd2, 1'b1, 1'b0);
      push_request(8'd3, 32'hFFFF_FFFF, 1'b0, 1'b1);
      push_request(8'd8, 32'd5, 1'b1, 1'b0);
      push_request(8'd12, 32'd9, 1'b0, 1'b0);
      push_request(8'd8, 32'd100, 1'b0, 1'b1);
      push_request(8'd14, 32'h8000_0000, 1'b1, 1'b0);
      end_requests();
      wait_drained();

      set_config(16'($urandom | $urandom), 16'($urandom), 16'($urandom),
                 rand_debounce_word(127), rand_debounce_word(127),
                 rand_debounce_word(127), rand_debounce_word(127));
      run_random(200, $urandom, 8);
      end_requests();
      wait_drained();

      // all ones, starting near the tick wrap, with a long hold on the result side
      set_config('1, '1, '1, '1, '1, '1, '1);
      send_idle = 1'b0;
      hold_asked++;
      run_random(40, 32'hFFFF_F000, 16384);
      send_idle = 1'b1;
      run_random(80, $urandom, 16384);
      end_requests();
      wait_drained();

      set_config('0, '0, '0, '0, '0, '0, '0);
      run_random(30, $urandom, 8);
      end_requests();
      wait_drained();

      set_config('1, '0, '0, '0, '0, '0, '0);
      run_random(100, 32'hFFFF_FFF0, 2);
      end_requests();
      wait_drained();

      set_config(16'($urandom), 16'($urandom), 16'($urandom), rand_debounce_word(300),
                 rand_debounce_word(300), rand_debounce_word(300),
                 rand_debounce_word(300));
      run_random(200, $urandom, 40);
      send_idle = 1'b0;
      recv_idle = 1'b0;
      run_random(100, $urandom, 40);
      end_requests();

      while (pending != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      drain_done <= 1'b1;
      repeat (2) @(negedge clock);

      $display("%0d requests over %0d csr settings, %0d results checked",
               sent_count, settings_count, checked_count);
      $display("%0d bounces rejected, %0d edge reports, %0d long output holds",
               bounce_count, report_count, hold_served);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/gedr_pkg.sv
hw/rtl/gedr_csr.sv
hw/rtl/gedr_tick_mem.sv
hw/rtl/gpio_edge_debounce_reporter_top.sv
bench/gedr_checker.sv
bench/tb_gpio_edge_debounce_reporter_top.sv
